>>> rtl/smsd_pkg.sv
// ----------------------------------------------------------------------------
// smsd_pkg: shared types and constants for the sliding median spike detector
// Widths, window limits, register map, sequencer states and the control
// bundle that drives the median scan unit.
// ----------------------------------------------------------------------------
package smsd_pkg;

    // Window and histogram geometry
    localparam int WINDOW_MAX = 1024;
    localparam int VALUE_BINS = 256;
    localparam int SAMPLE_W   = 8;
    localparam int COUNT_W    = 11;
    localparam int LEN_W      = 11;
    localparam int PTR_W      = $clog2(WINDOW_MAX);
    localparam int BIN_W      = $clog2(VALUE_BINS);
    localparam int CUM_W      = 12;
    localparam int DMED_W     = 9;
    localparam int TOTAL_W    = 32;

    // Packed stream widths
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 48;
    localparam int M_USED_W   = 1 + DMED_W + TOTAL_W;

    // Register map
    localparam int PADDR_W    = 3;
    localparam logic REG_WINDOW_LEN = 1'b0;

    // Sequencer states
    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_SCAN   = 9'b000000010,
        ST_OLD_RD = 9'b000000100,
        ST_OLD_WR = 9'b000001000,
        ST_NEW_RD = 9'b000010000,
        ST_NEW_WR = 9'b000100000,
        ST_DONE   = 9'b001000000,
        ST_SPARE0 = 9'b010000000,
        ST_SPARE1 = 9'b100000000
    } seq_state_t;

    // Control bundle into the median scan unit
    typedef struct packed {
        logic             start;
        logic             step;
        logic [BIN_W-1:0] bin;
    } scan_ctrl_t;

    // Clamp the programmed length to the supported window range
    function automatic logic [LEN_W-1:0] active_len(input logic [LEN_W-1:0] wl);
        logic [LEN_W-1:0] len;
        len = wl;
        if (wl == '0) begin
            len = LEN_W'(1);
        end else if (wl > LEN_W'(WINDOW_MAX)) begin
            len = LEN_W'(WINDOW_MAX);
        end
        return len;
    endfunction

endpackage

>>> rtl/smsd_ram.sv
// ----------------------------------------------------------------------------
// smsd_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module smsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/smsd_median.sv
// ----------------------------------------------------------------------------
// smsd_median: cumulative histogram scan unit
// Accumulates one bin count per step and latches the bins where the running
// sum first reaches the lower and upper middle ranks of the window.
// ----------------------------------------------------------------------------
module smsd_median (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  smsd_pkg::scan_ctrl_t          ctrl,
    input  logic [smsd_pkg::COUNT_W-1:0]  bin_count,
    input  logic [smsd_pkg::LEN_W-1:0]    win_len,
    output logic [smsd_pkg::DMED_W-1:0]   doubled_median
);

    logic [smsd_pkg::CUM_W-1:0] cum_reg, cum_next;
    logic [smsd_pkg::BIN_W-1:0] lo_reg, lo_next;
    logic [smsd_pkg::BIN_W-1:0] up_reg, up_next;
    logic                       got_lo_reg, got_lo_next;
    logic                       got_up_reg, got_up_next;
    logic [smsd_pkg::CUM_W-1:0] half;
    logic [smsd_pkg::CUM_W-1:0] lo_target;
    logic [smsd_pkg::CUM_W-1:0] up_target;
    logic [smsd_pkg::CUM_W-1:0] cum_sum;

    // Middle ranks: odd windows share one rank, even windows take two
    assign half      = smsd_pkg::CUM_W'(win_len >> 1);
    assign up_target = half + smsd_pkg::CUM_W'(1);
    assign lo_target = win_len[0] ? up_target : half;
    assign cum_sum   = cum_reg + smsd_pkg::CUM_W'(bin_count);

    // Advance the running sum and catch the rank crossings
    always_comb begin
        cum_next    = cum_reg;
        lo_next     = lo_reg;
        up_next     = up_reg;
        got_lo_next = got_lo_reg;
        got_up_next = got_up_reg;
        if (ctrl.start) begin
            cum_next    = '0;
            lo_next     = '0;
            up_next     = '0;
            got_lo_next = 1'b0;
            got_up_next = 1'b0;
        end else if (ctrl.step) begin
            cum_next = cum_sum;
            if (!got_lo_reg && cum_sum >= lo_target) begin
                lo_next     = ctrl.bin;
                got_lo_next = 1'b1;
            end
            if (!got_up_reg && cum_sum >= up_target) begin
                up_next     = ctrl.bin;
                got_up_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            got_lo_reg <= 1'b0;
            got_up_reg <= 1'b0;
        end else begin
            got_lo_reg <= got_lo_next;
            got_up_reg <= got_up_next;
        end
        cum_reg <= cum_next;
        lo_reg  <= lo_next;
        up_reg  <= up_next;
    end

    assign doubled_median = smsd_pkg::DMED_W'(lo_reg) + smsd_pkg::DMED_W'(up_reg);

endmodule

>>> rtl/sliding_median_spike_detector_unit.sv
// ----------------------------------------------------------------------------
// sliding_median_spike_detector_unit: sliding window median spike detector
// Keeps a counting histogram and a ring of the last window_len samples, scans
// the histogram for the doubled median and flags samples at or above it.
//
//   channel | direction | handshake         | payload
//   --------+-----------+-------------------+---------------------------------
//   s_      | in        | s_tvalid/s_tready | s_tdata: sample
//   m_      | out       | m_tvalid/m_tready | m_tdata: alert, doubled_median,
//           |           |                   |          alert_total
//   apb     | in        | psel/penable      | window_len at byte address 0
//
// A filling item passes through accept, histogram read and histogram write.
// A full-window item passes through accept, the median scan (one bin per
// cycle through the histogram RAM read port), the histogram update and the
// result register load; the update reads and writes the old and new bins.
// aresetn is synchronous; the histogram clears at once through per-bin valid
// bits, so no clearing pass follows reset. A result that is not taken holds
// in the output register; the next item is still accepted meanwhile.
// ----------------------------------------------------------------------------
module sliding_median_spike_detector_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [smsd_pkg::S_TDATA_W-1:0]    s_tdata,  // [7:0] sample
    // Result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [smsd_pkg::M_TDATA_W-1:0]    m_tdata,  // [0] alert,
                                                        // [9:1] doubled_median,
                                                        // [41:10] alert_total,
                                                        // [47:42] zero
    // Configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [smsd_pkg::PADDR_W-1:0]      paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    smsd_pkg::seq_state_t state_reg, state_next;

    logic [smsd_pkg::LEN_W-1:0]    window_len_reg;
    logic [smsd_pkg::LEN_W-1:0]    win_len;
    logic [smsd_pkg::LEN_W-1:0]    fill_reg, fill_next;
    logic [smsd_pkg::PTR_W-1:0]    ptr_reg, ptr_next;
    logic [smsd_pkg::SAMPLE_W-1:0] sample_reg;
    logic                          full_reg, full_next;
    logic [smsd_pkg::BIN_W-1:0]    scan_cnt_reg, scan_cnt_next;
    logic                          step_reg;
    logic [smsd_pkg::VALUE_BINS-1:0] bin_valid_reg;
    logic [smsd_pkg::TOTAL_W-1:0]  total_reg, total_next;
    logic                          m_tvalid_reg;
    logic [smsd_pkg::M_TDATA_W-1:0] m_tdata_reg;

    logic                          cfg_wr;
    logic                          accept;
    logic                          out_load;
    logic                          alert;
    logic [smsd_pkg::DMED_W-1:0]   dmed;

    // Histogram RAM signals
    logic [smsd_pkg::BIN_W-1:0]    hist_raddr;
    logic [smsd_pkg::BIN_W-1:0]    hist_addr_reg;
    logic [smsd_pkg::COUNT_W-1:0]  hist_rdata;
    logic [smsd_pkg::COUNT_W-1:0]  hist_count;
    logic                          hist_we;
    logic [smsd_pkg::COUNT_W-1:0]  hist_wdata;

    // Ring RAM signals
    logic                          ring_we;
    logic [smsd_pkg::SAMPLE_W-1:0] ring_rdata;

    smsd_pkg::scan_ctrl_t          scan_ctrl;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == smsd_pkg::REG_WINDOW_LEN);
    assign prdata = (paddr[2] == smsd_pkg::REG_WINDOW_LEN)
                  ? {{(32-smsd_pkg::LEN_W){1'b0}}, window_len_reg} : 32'd0;

    assign win_len  = smsd_pkg::active_len(window_len_reg);
    assign s_tready = (state_reg == smsd_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // Bins never written since the last clear read as zero
    assign hist_count = bin_valid_reg[hist_addr_reg] ? hist_rdata : '0;

    // Histogram read address per sequencer step
    always_comb begin
        case (state_reg)
            smsd_pkg::ST_SCAN:   hist_raddr = scan_cnt_reg;
            smsd_pkg::ST_OLD_RD: hist_raddr = smsd_pkg::BIN_W'(ring_rdata);
            smsd_pkg::ST_NEW_RD: hist_raddr = smsd_pkg::BIN_W'(sample_reg);
            default:             hist_raddr = '0;
        endcase
    end

    // Histogram write: drop the oldest sample once the window is full, add the new one
    always_comb begin
        hist_we    = 1'b0;
        hist_wdata = hist_count;
        case (state_reg)
            smsd_pkg::ST_OLD_WR: begin
                hist_we    = (hist_count != '0);
                hist_wdata = hist_count - smsd_pkg::COUNT_W'(1);
            end
            smsd_pkg::ST_NEW_WR: begin
                hist_we    = 1'b1;
                hist_wdata = hist_count + smsd_pkg::COUNT_W'(1);
            end
            default: begin
                hist_we = 1'b0;
            end
        endcase
    end

    assign ring_we = (state_reg == smsd_pkg::ST_NEW_WR);

    // Median scan unit control
    assign scan_ctrl.start = accept;
    assign scan_ctrl.step  = step_reg;
    assign scan_ctrl.bin   = hist_addr_reg;

    assign alert    = ({1'b0, sample_reg} >= dmed);
    assign out_load = (state_reg == smsd_pkg::ST_DONE) && (!m_tvalid_reg || m_tready);

    // Sequencer
    always_comb begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        ptr_next      = ptr_reg;
        full_next     = full_reg;
        scan_cnt_next = scan_cnt_reg;
        total_next    = total_reg;
        case (state_reg)
            smsd_pkg::ST_IDLE: begin
                if (accept) begin
                    full_next     = (fill_reg >= win_len);
                    scan_cnt_next = '0;
                    state_next    = (fill_reg >= win_len) ? smsd_pkg::ST_SCAN
                                                          : smsd_pkg::ST_NEW_RD;
                end
            end
            smsd_pkg::ST_SCAN: begin
                scan_cnt_next = scan_cnt_reg + smsd_pkg::BIN_W'(1);
                if (scan_cnt_reg == smsd_pkg::BIN_W'(smsd_pkg::VALUE_BINS - 1)) begin
                    state_next = smsd_pkg::ST_OLD_RD;
                end
            end
            smsd_pkg::ST_OLD_RD: begin
                state_next = smsd_pkg::ST_OLD_WR;
            end
            smsd_pkg::ST_OLD_WR: begin
                state_next = smsd_pkg::ST_NEW_RD;
            end
            smsd_pkg::ST_NEW_RD: begin
                state_next = smsd_pkg::ST_NEW_WR;
            end
            smsd_pkg::ST_NEW_WR: begin
                // Advance the ring pointer and the fill level
                if (({1'b0, ptr_reg} + smsd_pkg::LEN_W'(1)) == win_len) begin
                    ptr_next = '0;
                end else begin
                    ptr_next = ptr_reg + smsd_pkg::PTR_W'(1);
                end
                if (!full_reg) begin
                    fill_next  = fill_reg + smsd_pkg::LEN_W'(1);
                    state_next = smsd_pkg::ST_IDLE;
                end else begin
                    state_next = smsd_pkg::ST_DONE;
                end
            end
            smsd_pkg::ST_DONE: begin
                if (out_load) begin
                    if (alert && (total_reg != '1)) begin
                        total_next = total_reg + smsd_pkg::TOTAL_W'(1);
                    end
                    state_next = smsd_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = smsd_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= smsd_pkg::ST_IDLE;
            window_len_reg <= smsd_pkg::LEN_W'(1);
            fill_reg       <= '0;
            ptr_reg        <= '0;
            full_reg       <= 1'b0;
            scan_cnt_reg   <= '0;
            step_reg       <= 1'b0;
            bin_valid_reg  <= '0;
            total_reg      <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg    <= state_next;
            full_reg     <= full_next;
            scan_cnt_reg <= scan_cnt_next;
            step_reg     <= (state_reg == smsd_pkg::ST_SCAN);
            total_reg    <= total_next;
            if (cfg_wr) begin
                // Restart the window from empty
                window_len_reg <= pwdata[smsd_pkg::LEN_W-1:0];
                fill_reg       <= '0;
                ptr_reg        <= '0;
                bin_valid_reg  <= '0;
            end else begin
                fill_reg <= fill_next;
                ptr_reg  <= ptr_next;
                if (hist_we) begin
                    bin_valid_reg[hist_addr_reg] <= 1'b1;
                end
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        hist_addr_reg <= hist_raddr;
        if (accept) begin
            sample_reg <= s_tdata[smsd_pkg::SAMPLE_W-1:0];
        end
        if (out_load) begin
            m_tdata_reg <= {{(smsd_pkg::M_TDATA_W-smsd_pkg::M_USED_W){1'b0}},
                            total_next, dmed, alert};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Histogram of the window
    smsd_ram #(
        .WIDTH (smsd_pkg::COUNT_W),
        .DEPTH (smsd_pkg::VALUE_BINS)
    ) u_hist_ram (
        .aclk  (aclk),
        .we    (hist_we),
        .waddr (hist_addr_reg),
        .wdata (hist_wdata),
        .raddr (hist_raddr),
        .rdata (hist_rdata)
    );

    // Ring of samples in arrival order
    smsd_ram #(
        .WIDTH (smsd_pkg::SAMPLE_W),
        .DEPTH (smsd_pkg::WINDOW_MAX)
    ) u_ring_ram (
        .aclk  (aclk),
        .we    (ring_we),
        .waddr (ptr_reg),
        .wdata (sample_reg),
        .raddr (ptr_reg),
        .rdata (ring_rdata)
    );

    // Median scan unit
    smsd_median u_median (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .ctrl           (scan_ctrl),
        .bin_count      (hist_count),
        .win_len        (win_len),
        .doubled_median (dmed)
    );

endmodule
